[src/ocf_pkg.sv]
`default_nettype none

package ocf_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned OpW   = 2;
	localparam int unsigned DataW = 32;
	localparam int unsigned AddrW = 3;

	typedef logic [ByteW-1:0] byte_t;

	typedef enum logic [OpW-1:0] {
		OP_FUSE  = 2'd0,
		OP_DECAY = 2'd1,
		OP_ERASE = 2'd2
	} op_t;

	typedef enum logic [0:0] {
		REG_FULL_CONF = 1'b0,
		REG_TEMP_CONF = 1'b1
	} reg_idx_t;

	// map labels
	localparam byte_t LABEL_FIXED   = 8'd255;
	localparam byte_t LABEL_TEMP    = 8'd200;
	localparam byte_t LABEL_MISSING = 8'd128;
	localparam byte_t LABEL_FLOOR   = 8'd50;
	localparam byte_t LABEL_NONE    = 8'd0;

	// scan byte codes
	localparam byte_t DEV_FLOOR_LOW  = 8'd78;
	localparam byte_t DEV_FLOOR_HIGH = 8'd178;
	localparam byte_t DEV_MISSING    = 8'd1;
	localparam byte_t ERASE_ABOVE    = 8'd100;
	localparam byte_t BLOB_KEEP      = 8'd255;

	localparam byte_t FULL_CONF_RST = 8'd225;
	localparam byte_t TEMP_CONF_RST = 8'd38;

endpackage

`default_nettype wire

[src/occupancy_cell_fusion.sv]
// occupancy_cell_fusion: per-cell update of an occupancy grid map stream.
// Request channel (cell_valid/cell_ready) carries the operation, the cell's
// old label and confidence, and the scan's blocked and deviation bytes.
// Result channel (result_valid/result_ready) returns new_label and
// new_confidence, exactly one result per request, in order.
// A request passes through the input register, one level of decision logic
// and the result register. Throughput: one request per cycle while the
// receiver does not stall; the whole decision fits between the input register
// and the result register.
// When the receiver stalls, the result register holds and the input register
// fills behind it; cell_ready drops only when both are occupied.
// Reset (arst_n low, asynchronous) empties both stages and loads the
// confidence registers with 225 (full) and 38 (temporary).
// The APB port writes full_confidence at 0x0 and temporary_confidence at 0x4;
// pready is tied high. Write registers only while no request is in flight.
`default_nettype none

module occupancy_cell_fusion (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// request channel
	input  wire logic                          cell_valid,
	output logic                               cell_ready,
	input  wire logic [ocf_pkg::OpW-1:0]       operation,
	input  wire logic [ocf_pkg::ByteW-1:0]     old_label,
	input  wire logic [ocf_pkg::ByteW-1:0]     old_confidence,
	input  wire logic [ocf_pkg::ByteW-1:0]     blocked,
	input  wire logic [ocf_pkg::ByteW-1:0]     deviation,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_ready,
	output logic [ocf_pkg::ByteW-1:0]          new_label,
	output logic [ocf_pkg::ByteW-1:0]          new_confidence,
	// configuration
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ocf_pkg::AddrW-1:0]     paddr,
	input  wire logic [ocf_pkg::DataW-1:0]     pwdata,
	output logic [ocf_pkg::DataW-1:0]          prdata,
	output logic                               pready
);

	ocf_pkg::byte_t full_conf_q;
	ocf_pkg::byte_t temp_conf_q;
	logic           reg_sel;
	logic           reg_wr;

	logic                      valid_s1;
	logic [ocf_pkg::OpW-1:0]   op_s1;
	ocf_pkg::byte_t            label_s1;
	ocf_pkg::byte_t            conf_s1;
	ocf_pkg::byte_t            blk_s1;
	ocf_pkg::byte_t            dev_s1;

	logic           valid_s2;
	ocf_pkg::byte_t label_s2;
	ocf_pkg::byte_t conf_s2;

	logic           adv_s1;
	ocf_pkg::byte_t nl;
	ocf_pkg::byte_t nc;

	// configuration registers
	assign pready  = 1'b1;
	assign reg_sel = paddr[ocf_pkg::AddrW-1];
	assign reg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_conf_q <= ocf_pkg::FULL_CONF_RST;
			temp_conf_q <= ocf_pkg::TEMP_CONF_RST;
		end else if (reg_wr) begin
			case (reg_sel)
				ocf_pkg::REG_FULL_CONF: full_conf_q <= pwdata[ocf_pkg::ByteW-1:0];
				ocf_pkg::REG_TEMP_CONF: temp_conf_q <= pwdata[ocf_pkg::ByteW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			ocf_pkg::REG_FULL_CONF:
				prdata = {{(ocf_pkg::DataW-ocf_pkg::ByteW){1'b0}}, full_conf_q};
			ocf_pkg::REG_TEMP_CONF:
				prdata = {{(ocf_pkg::DataW-ocf_pkg::ByteW){1'b0}}, temp_conf_q};
			default:
				prdata = '0;
		endcase
	end

	// pipeline control
	assign adv_s1     = valid_s1 & (~valid_s2 | result_ready);
	assign cell_ready = ~valid_s1 | adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cell_ready) begin
			valid_s1 <= cell_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cell_valid && cell_ready) begin
			op_s1    <= operation;
			label_s1 <= old_label;
			conf_s1  <= old_confidence;
			blk_s1   <= blocked;
			dev_s1   <= deviation;
		end
	end

	// cell decision
	always_comb begin
		nl = label_s1;
		nc = conf_s1;
		case (op_s1)
			ocf_pkg::OP_FUSE: begin
				if (dev_s1 inside {[ocf_pkg::DEV_FLOOR_LOW:ocf_pkg::DEV_FLOOR_HIGH]}) begin
					nl = ocf_pkg::LABEL_FLOOR;
					nc = full_conf_q;
				end else if (dev_s1 == ocf_pkg::DEV_MISSING) begin
					// fill only empty or expired cells
					if (conf_s1 == '0 || label_s1 <= ocf_pkg::DEV_MISSING) begin
						nl = ocf_pkg::LABEL_MISSING;
						nc = full_conf_q;
					end
				end else if (blk_s1 != '0) begin
					// obstacle over known floor or temporary: treat as moving
					if (conf_s1 != '0 &&
					    (label_s1 == ocf_pkg::LABEL_FLOOR || label_s1 == ocf_pkg::LABEL_TEMP)) begin
						nl = ocf_pkg::LABEL_TEMP;
						nc = (conf_s1 < temp_conf_q) ? conf_s1 : temp_conf_q;
					end else begin
						nl = ocf_pkg::LABEL_FIXED;
						nc = full_conf_q;
					end
				end else if (dev_s1 > ocf_pkg::DEV_MISSING) begin
					nc = full_conf_q;
				end
			end
			ocf_pkg::OP_DECAY: begin
				nc = (conf_s1 != '0) ? conf_s1 - 8'd1 : conf_s1;
			end
			ocf_pkg::OP_ERASE: begin
				if (label_s1 > ocf_pkg::ERASE_ABOVE && blk_s1 != ocf_pkg::BLOB_KEEP)
					nl = ocf_pkg::LABEL_NONE;
			end
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (~valid_s2 | result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			label_s2 <= nl;
			conf_s2  <= nc;
		end
	end

	assign result_valid   = valid_s2;
	assign new_label      = label_s2;
	assign new_confidence = conf_s2;

`ifndef SYNTH
	a_ready_low_full: assert property (@(posedge clk) disable iff (!arst_n)
		!cell_ready |-> (valid_s1 && valid_s2 && !result_ready))
		else $error("request stage stalled while a slot was free");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		cell_valid && cell_ready |=> valid_s1)
		else $error("accepted request lost from input stage");

	a_stall_keeps: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !result_ready |=> valid_s1 && valid_s2)
		else $error("item dropped during stall");

	a_decay: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == ocf_pkg::OP_DECAY |=>
		(new_confidence == (($past(conf_s1) == 8'd0) ? 8'd0 : $past(conf_s1) - 8'd1)))
		else $error("decay result wrong");

	a_erase_never_raises: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && op_s1 == ocf_pkg::OP_ERASE |=>
		(new_label <= $past(label_s1) && new_confidence == $past(conf_s1)))
		else $error("erase changed more than the label");
`endif

endmodule

`default_nettype wire

[test/tb_occupancy_cell_fusion.sv]
`default_nettype none

module tb_occupancy_cell_fusion;
	timeunit 1ns;
	timeprecision 1ps;

	import ocf_pkg::*;

	localparam logic [OpW-1:0] OP_UNUSED = 2'd3;
	localparam int unsigned GAP_MAX = 20;
	localparam int unsigned SETTLE_CYCLES = 4;

	typedef struct packed {
		byte_t label;
		byte_t conf;
	} cell_update_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cell_valid = 1'b0;
	logic cell_ready;
	logic [OpW-1:0] operation = '0;
	byte_t old_label = '0;
	byte_t old_confidence = '0;
	byte_t blocked = '0;
	byte_t deviation = '0;

	logic result_valid;
	logic result_ready = 1'b0;
	byte_t new_label;
	byte_t new_confidence;

	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [AddrW-1:0] paddr = '0;
	logic [DataW-1:0] pwdata = '0;
	logic [DataW-1:0] prdata;
	logic pready;

	// testbench copy of the confidence registers
	byte_t full_conf_q = FULL_CONF_RST;
	byte_t temp_conf_q = TEMP_CONF_RST;

	cell_update_t pending_updates[$];
	cell_update_t oldest_update;
	int unsigned errors = 0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	bit req_up = 1'b0;

	occupancy_cell_fusion i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cell_valid     (cell_valid),
		.cell_ready     (cell_ready),
		.operation      (operation),
		.old_label      (old_label),
		.old_confidence (old_confidence),
		.blocked        (blocked),
		.deviation      (deviation),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.new_label      (new_label),
		.new_confidence (new_confidence),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	function automatic cell_update_t fuse_cell_update(logic [OpW-1:0] op, byte_t lab,
			byte_t cf, byte_t blk, byte_t dev);
		cell_update_t upd;
		upd.label = lab;
		upd.conf  = cf;
		case (op)
			OP_FUSE: begin
				if (dev >= DEV_FLOOR_LOW && dev <= DEV_FLOOR_HIGH) begin
					upd.label = LABEL_FLOOR;
					upd.conf  = full_conf_q;
				end else if (dev == DEV_MISSING) begin
					// missing depth only fills empty or expired cells
					if (cf == 8'd0 || lab <= 8'd1) begin
						upd.label = LABEL_MISSING;
						upd.conf  = full_conf_q;
					end
				end else if (blk != 8'd0) begin
					if (cf != 8'd0 && (lab == LABEL_FLOOR || lab == LABEL_TEMP)) begin
						upd.label = LABEL_TEMP;
						upd.conf  = (cf < temp_conf_q) ? cf : temp_conf_q;
					end else begin
						upd.label = LABEL_FIXED;
						upd.conf  = full_conf_q;
					end
				end else if (dev > DEV_MISSING) begin
					upd.conf = full_conf_q;
				end
			end
			OP_DECAY: begin
				upd.conf = (cf != 8'd0) ? cf - 8'd1 : 8'd0;
			end
			OP_ERASE: begin
				if (lab > ERASE_ABOVE && blk != BLOB_KEEP)
					upd.label = LABEL_NONE;
			end
			default: begin
			end
		endcase
		return upd;
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_updates.size() == 0) begin
				errors++;
				$display("%0t: unexpected result label %0d confidence %0d",
					$time, new_label, new_confidence);
			end else begin
				oldest_update = pending_updates.pop_front();
				if (new_label !== oldest_update.label) begin
					errors++;
					$display("%0t: new_label expected %0d actual %0d",
						$time, oldest_update.label, new_label);
				end
				if (new_confidence !== oldest_update.conf) begin
					errors++;
					$display("%0t: new_confidence expected %0d actual %0d",
						$time, oldest_update.conf, new_confidence);
				end
			end
		end
	end

	task automatic send_cell(input logic [OpW-1:0] op, input byte_t lab, input byte_t cf,
			input byte_t blk, input byte_t dev);
		int unsigned gap;
		cell_valid     <= 1'b1;
		operation      <= op;
		old_label      <= lab;
		old_confidence <= cf;
		blocked        <= blk;
		deviation      <= dev;
		req_up = 1'b1;
		@(posedge clk);
		while (!cell_ready) @(posedge clk);
		pending_updates.push_back(fuse_cell_update(op, lab, cf, blk, dev));
		gap = 0;
		while (gap < GAP_MAX && $urandom_range(99) < sender_idle_pct) gap++;
		if (gap > 0) begin
			cell_valid <= 1'b0;
			req_up = 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_random_cell();
		logic [OpW-1:0] op;
		byte_t lab;
		byte_t cf;
		byte_t blk;
		byte_t dev;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 55)
			op = OP_FUSE;
		else if (pick < 72)
			op = OP_DECAY;
		else if (pick < 92)
			op = OP_ERASE;
		else
			op = OP_UNUSED;
		case ($urandom_range(7))
			0: lab = LABEL_NONE;
			1: lab = 8'd1;
			2: lab = LABEL_FLOOR;
			3: lab = LABEL_TEMP;
			4: lab = LABEL_MISSING;
			5: lab = LABEL_FIXED;
			6: lab = ERASE_ABOVE + 8'($urandom_range(1));
			default: lab = 8'($urandom);
		endcase
		case ($urandom_range(4))
			0: cf = 8'd0;
			1: cf = 8'd255;
			// land around the temporary cap
			2: cf = temp_conf_q + 8'($urandom_range(2)) - 8'd1;
			default: cf = 8'($urandom);
		endcase
		case ($urandom_range(3))
			0: blk = 8'd0;
			1: blk = BLOB_KEEP;
			default: blk = 8'($urandom);
		endcase
		case ($urandom_range(6))
			0: dev = 8'd0;
			1: dev = DEV_MISSING;
			2: dev = DEV_FLOOR_LOW - 8'($urandom_range(1));
			3: dev = DEV_FLOOR_HIGH + 8'($urandom_range(1));
			default: dev = 8'($urandom);
		endcase
		send_cell(op, lab, cf, blk, dev);
	endtask

	task automatic lower_request();
		if (req_up) begin
			cell_valid <= 1'b0;
			req_up = 1'b0;
		end
	endtask

	task automatic wait_until_drained();
		lower_request();
		while (pending_updates.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_transfer(input logic wr, input reg_idx_t idx, input byte_t wdata,
			output logic [DataW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= AddrW'({idx, 2'b00});
		pwdata  <= DataW'(wdata);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		if (wr) begin
			if (idx == REG_FULL_CONF)
				full_conf_q = wdata;
			else
				temp_conf_q = wdata;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_register(input reg_idx_t idx, input byte_t want);
		logic [DataW-1:0] rdata;
		apb_transfer(1'b0, idx, 8'd0, rdata);
		if (rdata !== DataW'(want)) begin
			errors++;
			$display("%0t: register %s expected %0d actual %0d",
				$time, idx.name(), want, rdata);
		end
	endtask

	task automatic write_register(input reg_idx_t idx, input byte_t value);
		logic [DataW-1:0] rdata;
		apb_transfer(1'b1, idx, value, rdata);
		check_register(idx, value);
	endtask

	task automatic set_confidences(input byte_t full, input byte_t temp);
		wait_until_drained();
		write_register(REG_FULL_CONF, full);
		write_register(REG_TEMP_CONF, temp);
	endtask

	task automatic run_cell_stream(input int unsigned count);
		repeat (count) send_random_cell();
	endtask

	task automatic test_reset_registers();
		check_register(REG_FULL_CONF, FULL_CONF_RST);
		check_register(REG_TEMP_CONF, TEMP_CONF_RST);
	endtask

	task automatic test_directed_cells();
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		// floor window edges
		send_cell(OP_FUSE, LABEL_NONE, 8'd0, 8'd0, DEV_FLOOR_LOW - 8'd1);
		send_cell(OP_FUSE, LABEL_FIXED, 8'd255, 8'd255, DEV_FLOOR_LOW);
		send_cell(OP_FUSE, LABEL_TEMP, 8'd3, 8'd9, DEV_FLOOR_HIGH);
		send_cell(OP_FUSE, LABEL_FLOOR, 8'd200, 8'd7, DEV_FLOOR_HIGH + 8'd1);
		// missing depth
		send_cell(OP_FUSE, LABEL_NONE, 8'd90, 8'd0, DEV_MISSING);
		send_cell(OP_FUSE, 8'd1, 8'd90, 8'd4, DEV_MISSING);
		send_cell(OP_FUSE, 8'd2, 8'd0, 8'd0, DEV_MISSING);
		send_cell(OP_FUSE, LABEL_TEMP, 8'd5, 8'd255, DEV_MISSING);
		// obstacles over floor, temporary and other cells
		send_cell(OP_FUSE, LABEL_FLOOR, 8'd10, 8'd1, 8'd0);
		send_cell(OP_FUSE, LABEL_TEMP, 8'd37, 8'd128, 8'd255);
		send_cell(OP_FUSE, LABEL_FLOOR, 8'd0, 8'd255, 8'd0);
		send_cell(OP_FUSE, LABEL_MISSING, 8'd99, 8'd3, 8'd2);
		// failed fit and no data without obstacle, then an obstacle and decay
		send_cell(OP_FUSE, LABEL_TEMP, 8'd9, 8'd0, 8'd2);
		send_cell(OP_FUSE, 8'd77, 8'd66, 8'd0, 8'd0);
		send_cell(OP_FUSE, LABEL_FIXED, 8'd255, 8'd255, 8'd255);
		send_cell(OP_DECAY, LABEL_FLOOR, 8'd0, 8'd0, 8'd0);
		send_cell(OP_DECAY, LABEL_FIXED, 8'd255, 8'd255, 8'd255);
		send_cell(OP_DECAY, LABEL_TEMP, 8'd1, 8'd0, 8'd90);
		// erase threshold and blob keep
		send_cell(OP_ERASE, ERASE_ABOVE, 8'd20, 8'd0, 8'd0);
		send_cell(OP_ERASE, ERASE_ABOVE + 8'd1, 8'd20, 8'd0, 8'd0);
		send_cell(OP_ERASE, LABEL_FIXED, 8'd255, BLOB_KEEP, 8'd255);
		send_cell(OP_ERASE, LABEL_FIXED, 8'd255, BLOB_KEEP - 8'd1, 8'd255);
		send_cell(OP_UNUSED, 8'd255, 8'd255, 8'd255, 8'd255);
		send_cell(OP_UNUSED, 8'd0, 8'd0, 8'd0, 8'd0);
	endtask

	task automatic test_sender_gaps();
		set_confidences(8'd0, 8'd0);
		sender_idle_pct    = 57;
		receiver_stall_pct = 0;
		run_cell_stream(310);
	endtask

	task automatic test_receiver_stalls();
		set_confidences(8'd255, 8'd255);
		sender_idle_pct    = 0;
		receiver_stall_pct = 57;
		run_cell_stream(310);
	endtask

	task automatic test_both_sides_idle();
		set_confidences(8'd255, 8'd0);
		sender_idle_pct    = 37;
		receiver_stall_pct = 37;
		run_cell_stream(310);
	endtask

	task automatic test_back_to_back();
		set_confidences(8'($urandom), 8'($urandom));
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		run_cell_stream(310);
	endtask

	task automatic test_pause_until_drained();
		set_confidences(8'($urandom), 8'($urandom));
		sender_idle_pct    = 37;
		receiver_stall_pct = 57;
		run_cell_stream(155);
		// hold off new requests until every result is back
		lower_request();
		while (pending_updates.size() != 0) @(posedge clk);
		run_cell_stream(155);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_registers();
		test_directed_cells();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_sides_idle();
		test_back_to_back();
		test_pause_until_drained();
		wait_until_drained();
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2ms;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
